FILE: rtl/wsp_pkg.sv
`default_nettype none

package wsp_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned NUM_COEF  = 16;
  localparam int unsigned WIN_W     = 14;
  localparam int unsigned REG_IDX_W = 1;

  // Quotient bits produced per divide; one bit above the 32-bit result
  // range is enough to detect saturation.
  localparam int unsigned QUO_BITS = DATA_W + 1;
  // Product stage, range check stage, one stage per quotient bit, saturate.
  localparam int unsigned DIV_LAT  = QUO_BITS + 3;

  localparam logic [WIN_W-1:0] WIDTH_RST  = 14'd640;
  localparam logic [WIN_W-1:0] HEIGHT_RST = 14'd480;

  typedef logic signed [DATA_W-1:0] wsp_word_t;
  typedef logic [WIN_W-1:0]         wsp_win_t;

  typedef enum logic {
    ACT_XFORM = 1'b0,
    ACT_LOAD  = 1'b1
  } wsp_act_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } wsp_reg_e;

endpackage

`default_nettype wire

FILE: rtl/wsp_in_if.sv
`default_nettype none

interface wsp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [wsp_pkg::IDX_W-1:0]        coef_index;
  wsp_pkg::wsp_word_t               coef_value;
  wsp_pkg::wsp_word_t               pos_x;
  wsp_pkg::wsp_word_t               pos_y;
  wsp_pkg::wsp_word_t               pos_z;

  modport source (
    output valid, action, coef_index, coef_value, pos_x, pos_y, pos_z,
    input  ready
  );

  modport sink (
    input  valid, action, coef_index, coef_value, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/wsp_out_if.sv
`default_nettype none

interface wsp_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  wsp_pkg::wsp_word_t screen_x;
  wsp_pkg::wsp_word_t screen_y;

  modport source (
    output valid, visible, screen_x, screen_y,
    input  ready
  );

  modport sink (
    input  valid, visible, screen_x, screen_y,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/world_to_screen_projector.sv
// World-to-screen projector: 3D point through a 4x4 column-major matrix to
// window pixel coordinates, signed fixed point with FRAC_BITS fraction bits.
// in_i carries one word per item: a load word (action = load) writes one
// matrix coefficient and gives no result; a transform word gives exactly one
// out_o word (visible, screen_x, screen_y). Points with clip w below 0.1 come
// out with visible low and both coordinates zero.
// cfg_we_i / cfg_idx_i / cfg_wdata_i set the window width (index 0) and
// height (index 1); write them only while no transform is in flight.
// Throughput: one word per cycle on both channels while out_o is not stalled.
// Pipeline: four stages form the clip coordinates and the signed numerators;
// the divider follows, one quotient bit per stage over 33 stages plus
// product, range and saturation stages, and then the output word register.
// Reset: coefficients clear to zero, window goes to 640 x 480, pipeline
// empties. A load takes effect for every transform accepted after it.
// Stall: while an out_o word waits, the whole pipeline holds; in_i stays
// ready as long as the first stage holds a bubble, so one more word can
// still enter.
`default_nettype none

module world_to_screen_projector #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  wsp_in_if.sink                             in_i,
  wsp_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [wsp_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wsp_pkg::WIN_W-1:0]          cfg_wdata_i
);

  // Floored product, clip sum, numerator widths
  localparam int unsigned PW = 64 - FRAC_BITS;
  localparam int unsigned CW = PW + 2;
  localparam int unsigned AW = CW + 1;
  localparam int unsigned DL = wsp_pkg::DIV_LAT;

  // 10 * w >= 1.0 is the exact test for w >= 0.1
  localparam logic signed [CW+3:0] VisMin = (CW+4)'(64'd1 << FRAC_BITS);

  // Matrix rows that feed clip x, y and w
  localparam int unsigned RowSel [3] = '{0, 1, 3};

  // Handshake / pipeline control
  logic adv;
  logic s1_en;
  logic acc;
  logic v1_q, v2_q, v3_q, v4_q;
  logic [DL-1:0] vd_q;
  logic [DL-1:0] visd_q;

  // Registers and coefficient store
  wsp_pkg::wsp_win_t  width_q, height_q;
  wsp_pkg::wsp_word_t coef_q [wsp_pkg::NUM_COEF];

  // Stage 1: floored products
  wsp_pkg::wsp_word_t pos [3];
  logic signed [63:0]   prod [3][3];
  logic signed [PW-1:0] p_q  [3][3];
  wsp_pkg::wsp_word_t   t_q  [3];

  // Stage 2: clip x, y, w
  logic signed [CW-1:0] sum_q [3];

  // Stage 3: visibility, numerators, denominator
  logic signed [CW+3:0] cw_ext;
  logic signed [CW+3:0] cw10;
  logic                 vis3_q;
  logic signed [AW-1:0] ax3_q, ay3_q;
  logic [CW-1:0]        den3_q;

  // Stage 4: sign and magnitude
  logic                 vis4_q;
  logic                 negx4_q, negy4_q;
  logic [AW-1:0]        magx4_q, magy4_q;
  logic [CW-1:0]        den4_q;

  // Divider results and output word
  wsp_pkg::wsp_word_t divx, divy;
  logic               out_valid_q;
  logic               out_vis_q;
  wsp_pkg::wsp_word_t out_x_q, out_y_q;

  // Advance everything unless the output word is stuck; the first stage can
  // still fill a bubble while stuck.
  assign adv   = !out_valid_q || out_o.ready;
  assign s1_en = adv || !v1_q;
  assign acc   = in_i.valid && s1_en;
  assign in_i.ready = s1_en;

  // Window size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wsp_pkg::WIDTH_RST;
      height_q <= wsp_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (wsp_pkg::wsp_reg_e'(cfg_idx_i))
        wsp_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i;
        wsp_pkg::REG_HEIGHT: height_q <= cfg_wdata_i;
        default:             width_q  <= width_q;
      endcase
    end
  end

  // Coefficient store: written by load words at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wsp_pkg::NUM_COEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (acc && (in_i.action == wsp_pkg::ACT_LOAD)) begin
      coef_q[in_i.coef_index] <= in_i.coef_value;
    end
  end

  assign pos[0] = in_i.pos_x;
  assign pos[1] = in_i.pos_y;
  assign pos[2] = in_i.pos_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign prod[r][c] = pos[c] * coef_q[4*c + RowSel[r]];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      vd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        v1_q <= acc && (in_i.action == wsp_pkg::ACT_XFORM);
      end
      if (adv) begin
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        v4_q        <= v3_q;
        vd_q        <= {vd_q[DL-2:0], v4_q};
        out_valid_q <= vd_q[DL-1];
      end
    end
  end

  // Stage 1: products floored by FRAC_BITS, translation column
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[r][c] <= PW'(prod[r][c] >>> FRAC_BITS);
        end
        t_q[r] <= coef_q[12 + RowSel[r]];
      end
    end
  end

  assign cw_ext = (CW+4)'(sum_q[2]);
  assign cw10   = (cw_ext <<< 3) + (cw_ext <<< 1);

  // Stages 2 to 4 and output word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= CW'(p_q[r][0]) + CW'(p_q[r][1]) + CW'(p_q[r][2]) + CW'(t_q[r]);
      end

      vis3_q <= cw10 >= VisMin;
      ax3_q  <= AW'(sum_q[0]) + AW'(sum_q[2]);
      ay3_q  <= AW'(sum_q[2]) - AW'(sum_q[1]);
      den3_q <= {sum_q[2][CW-2:0], 1'b0};

      vis4_q  <= vis3_q;
      negx4_q <= ax3_q[AW-1];
      negy4_q <= ay3_q[AW-1];
      magx4_q <= ax3_q[AW-1] ? AW'(-ax3_q) : AW'(ax3_q);
      magy4_q <= ay3_q[AW-1] ? AW'(-ay3_q) : AW'(ay3_q);
      den4_q  <= den3_q;

      visd_q <= {visd_q[DL-2:0], vis4_q};

      // Drop the divider output for points behind the near limit
      out_vis_q <= visd_q[DL-1];
      out_x_q   <= visd_q[DL-1] ? divx : '0;
      out_y_q   <= visd_q[DL-1] ? divy : '0;
    end
  end

  wsp_divider #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (AW),
    .DEN_W     (CW)
  ) u_div_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .neg_i   (negx4_q),
    .mag_i   (magx4_q),
    .den_i   (den4_q),
    .scale_i (width_q),
    .res_o   (divx)
  );

  wsp_divider #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (AW),
    .DEN_W     (CW)
  ) u_div_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .neg_i   (negy4_q),
    .mag_i   (magy4_q),
    .den_i   (den4_q),
    .scale_i (height_q),
    .res_o   (divy)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.visible  = out_vis_q;
  assign out_o.screen_x = out_x_q;
  assign out_o.screen_y = out_y_q;

endmodule

`default_nettype wire

FILE: rtl/wsp_divider.sv
`default_nettype none

// Pipelined floor(+-mag * scale * 2^FRAC_BITS / den), saturated to 32 bits.
// One restoring quotient bit per stage.
module wsp_divider #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MAG_W     = 51,
  parameter int unsigned DEN_W     = 50
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       neg_i,
  input  logic [MAG_W-1:0]           mag_i,
  input  logic [DEN_W-1:0]           den_i,
  input  wsp_pkg::wsp_win_t          scale_i,
  output wsp_pkg::wsp_word_t         res_o
);

  localparam int unsigned QB   = wsp_pkg::QUO_BITS;
  localparam int unsigned OW   = wsp_pkg::DATA_W;
  localparam int unsigned PRW  = MAG_W + wsp_pkg::WIN_W;
  localparam int unsigned NW   = PRW + FRAC_BITS;
  localparam int unsigned HW   = NW - QB;
  localparam int unsigned RW   = DEN_W + 1;
  localparam int unsigned CMPW = (HW > DEN_W) ? HW : DEN_W;

  localparam wsp_pkg::wsp_word_t SatPos = {1'b0, {(OW-1){1'b1}}};
  localparam wsp_pkg::wsp_word_t SatNeg = {1'b1, {(OW-1){1'b0}}};

  // Product stage
  logic [PRW-1:0]   prod_q;
  logic             neg_a_q;
  logic [DEN_W-1:0] den_a_q;

  // Range check
  logic [NW-1:0]    num;
  logic [HW-1:0]    num_hi;
  logic             ovf;

  // Quotient stages
  logic [RW-1:0]    rem_q [QB+1];
  logic [QB-1:0]    q_q   [QB+1];
  logic [QB-1:0]    lo_q  [QB];
  logic [DEN_W-1:0] den_q [QB];
  logic [QB:0]      neg_q;
  logic [QB:0]      ovf_q;
  logic [RW-1:0]    trial [QB];
  logic [QB-1:0]    take;

  // Saturation
  logic [QB-1:0]      q_fin;
  logic               inexact;
  wsp_pkg::wsp_word_t res_d;
  wsp_pkg::wsp_word_t res_q;

  assign num    = {prod_q, {FRAC_BITS{1'b0}}};
  assign num_hi = num[NW-1:QB];
  // Quotient needs more than QB bits: saturate regardless of sign.
  assign ovf    = CMPW'(num_hi) >= CMPW'(den_a_q);

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem_q[k][RW-2:0], lo_q[k][QB-1]};
      take[k]  = trial[k] >= RW'(den_q[k]);
    end
  end

  always_comb begin
    q_fin   = q_q[QB];
    inexact = |rem_q[QB];
    if (neg_q[QB]) begin
      if (ovf_q[QB] || q_fin[QB-1] ||
          (q_fin[OW-1] && ((|q_fin[OW-2:0]) || inexact))) begin
        res_d = SatNeg;
      end else if (inexact) begin
        // floor of a negative inexact quotient: -(q + 1)
        res_d = ~q_fin[OW-1:0];
      end else begin
        res_d = -q_fin[OW-1:0];
      end
    end else begin
      if (ovf_q[QB] || (|q_fin[QB-1:OW-1])) begin
        res_d = SatPos;
      end else begin
        res_d = q_fin[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= PRW'(mag_i) * PRW'(scale_i);
      neg_a_q  <= neg_i;
      den_a_q  <= den_i;

      rem_q[0] <= RW'(num_hi);
      lo_q[0]  <= num[QB-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_a_q;
      neg_q[0] <= neg_a_q;
      ovf_q[0] <= ovf;

      for (int k = 0; k < QB; k++) begin
        rem_q[k+1] <= take[k] ? (trial[k] - RW'(den_q[k])) : trial[k];
        q_q[k+1]   <= {q_q[k][QB-2:0], take[k]};
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
        if (k < QB - 1) begin
          lo_q[k+1]  <= {lo_q[k][QB-2:0], 1'b0};
          den_q[k+1] <= den_q[k];
        end
      end

      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/wsp_checker.sv
`default_nettype none

module wsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_visible_i,
  input wsp_pkg::wsp_word_t out_x_i,
  input wsp_pkg::wsp_word_t out_y_i
);

  // A waiting output word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_visible_i) && $stable(out_x_i) && $stable(out_y_i))
    else $error("output word changed while stalled");

  // Hidden points carry zero coordinates
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_visible_i |-> (out_x_i == '0) && (out_y_i == '0))
    else $error("hidden point with nonzero coordinates");

  // Pipeline moves whenever the output side is free
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready with empty output");

  a_ready_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input not ready while output is taken");

endmodule

bind world_to_screen_projector wsp_checker u_wsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_visible_i (out_o.visible),
  .out_x_i       (out_o.screen_x),
  .out_y_i       (out_o.screen_y)
);

`default_nettype wire
